// ----- sv/oldv_pkg.sv -----
package oldv_pkg;

    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;

    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    localparam int OPCODE_W = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int ECOUNT_W = 7;

    localparam logic [OPCODE_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_QUERY  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOMATCH = 2'd2;

    typedef struct packed {
        logic                load_key;
        logic                append;
        logic                walk_init_scan;
        logic                walk_init_shift;
        logic                walk_step;
        logic                shift_wr;
        logic                dec_count;
        logic                load_result;
        logic                res_found;
        logic [STATUS_W-1:0] res_status;
    } cmd_t;

    typedef struct packed {
        logic match;
        logic walk_done;
        logic full;
        logic out_free;
    } sts_t;

endpackage

// ----- sv/oldv_if.sv -----
interface oldv_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [oldv_pkg::OPCODE_W-1:0]        opcode;
    logic signed [oldv_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface oldv_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          found;
    logic [oldv_pkg::STATUS_W-1:0] status;
    logic [oldv_pkg::ECOUNT_W-1:0] entry_count;

    modport source (output valid, output found, output status, output entry_count, input ready);
    modport sink   (input valid, input found, input status, input entry_count, output ready);
endinterface

// ----- sv/oldv_datapath.sv -----
module oldv_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  oldv_pkg::cmd_t                       cmd,
    output oldv_pkg::sts_t                       sts,
    input  logic signed [oldv_pkg::VALUE_W-1:0]  value,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 out_found,
    output logic [oldv_pkg::STATUS_W-1:0]        out_status,
    output logic [oldv_pkg::ECOUNT_W-1:0]        out_count
);

    logic [oldv_pkg::DATA_WIDTH-1:0] mem [oldv_pkg::CAPACITY];

    logic [oldv_pkg::DATA_WIDTH-1:0] key_reg;
    logic [oldv_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [oldv_pkg::CNT_W-1:0]      ptr_reg, ptr_next;
    logic                            rd_vld_reg, rd_vld_next;
    logic [oldv_pkg::CNT_W-1:0]      rd_idx_reg;
    logic [oldv_pkg::DATA_WIDTH-1:0] rd_data_reg;
    logic                            out_valid_reg, out_valid_next;
    logic                            found_reg;
    logic [oldv_pkg::STATUS_W-1:0]   status_reg;
    logic [oldv_pkg::ECOUNT_W-1:0]   ecount_reg;

    logic                            issue;
    logic                            wr_en;
    logic [oldv_pkg::ADDR_W-1:0]     wr_addr;
    logic [oldv_pkg::DATA_WIDTH-1:0] wr_data;
    logic [oldv_pkg::CNT_W-1:0]      shift_dst;

    // Issue a read only while entries remain ahead of the walk pointer
    assign issue     = cmd.walk_step && (ptr_reg < count_reg);
    assign shift_dst = rd_idx_reg - oldv_pkg::CNT_W'(1);

    assign wr_en   = cmd.append || (cmd.shift_wr && rd_vld_reg);
    assign wr_addr = cmd.append ? count_reg[oldv_pkg::ADDR_W-1:0]
                                : shift_dst[oldv_pkg::ADDR_W-1:0];
    assign wr_data = cmd.append ? key_reg : rd_data_reg;

    always_comb
    begin
        priority if (cmd.walk_init_scan)
        begin
            ptr_next = '0;
        end
        else if (cmd.walk_init_shift)
        begin
            ptr_next = rd_idx_reg + oldv_pkg::CNT_W'(1);
        end
        else if (issue)
        begin
            ptr_next = ptr_reg + oldv_pkg::CNT_W'(1);
        end
        else
        begin
            ptr_next = ptr_reg;
        end
    end

    assign rd_vld_next = issue && !cmd.walk_init_scan && !cmd.walk_init_shift;

    always_comb
    begin
        priority if (cmd.append)
        begin
            count_next = count_reg + oldv_pkg::CNT_W'(1);
        end
        else if (cmd.dec_count)
        begin
            count_next = count_reg - oldv_pkg::CNT_W'(1);
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_comb
    begin
        priority if (cmd.load_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ptr_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            rd_vld_reg    <= rd_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Entry store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (issue)
        begin
            rd_data_reg <= mem[ptr_reg[oldv_pkg::ADDR_W-1:0]];
            rd_idx_reg  <= ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_key)
        begin
            key_reg <= oldv_pkg::DATA_WIDTH'($unsigned(value));
        end
        if (cmd.load_result)
        begin
            found_reg  <= cmd.res_found;
            status_reg <= cmd.res_status;
            ecount_reg <= oldv_pkg::ECOUNT_W'(count_reg);
        end
    end

    assign sts.match     = rd_vld_reg && (rd_data_reg == key_reg);
    assign sts.walk_done = !rd_vld_reg && !(ptr_reg < count_reg);
    assign sts.full      = (count_reg >= oldv_pkg::CNT_W'(oldv_pkg::CAPACITY));
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_found  = found_reg;
    assign out_status = status_reg;
    assign out_count  = ecount_reg;

endmodule

// ----- sv/oldv_ctrl.sv -----
module oldv_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [oldv_pkg::OPCODE_W-1:0] opcode,
    input  oldv_pkg::sts_t                sts,
    output oldv_pkg::cmd_t                cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_APPEND = 5'b00010,
        S_SCAN   = 5'b00100,
        S_SHIFT  = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

    state_t                        state_reg, state_next;
    logic [oldv_pkg::OPCODE_W-1:0] op_reg, op_next;
    logic                          found_reg, found_next;
    logic [oldv_pkg::STATUS_W-1:0] status_reg, status_next;
    logic                          accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        found_next  = found_reg;
        status_next = status_reg;
        cmd         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load_key = 1'b1;
                    op_next      = opcode;
                    found_next   = 1'b0;
                    status_next  = oldv_pkg::ST_OK;
                    unique case (opcode)
                        oldv_pkg::OP_APPEND:
                        begin
                            state_next = S_APPEND;
                        end
                        oldv_pkg::OP_DELETE, oldv_pkg::OP_QUERY:
                        begin
                            cmd.walk_init_scan = 1'b1;
                            state_next         = S_SCAN;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_APPEND:
            begin
                if (sts.full)
                begin
                    status_next = oldv_pkg::ST_FULL;
                end
                else
                begin
                    cmd.append = 1'b1;
                end
                state_next = S_DONE;
            end
            S_SCAN:
            begin
                priority if (sts.match)
                begin
                    found_next = 1'b1;
                    if (op_reg == oldv_pkg::OP_DELETE)
                    begin
                        cmd.walk_init_shift = 1'b1;
                        state_next          = S_SHIFT;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else if (sts.walk_done)
                begin
                    if (op_reg == oldv_pkg::OP_DELETE)
                    begin
                        status_next = oldv_pkg::ST_NOMATCH;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                end
            end
            S_SHIFT:
            begin
                cmd.shift_wr = 1'b1;
                if (sts.walk_done)
                begin
                    cmd.dec_count = 1'b1;
                    state_next    = S_DONE;
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        cmd.res_found  = found_reg;
        cmd.res_status = status_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            op_reg     <= oldv_pkg::OP_APPEND;
            found_reg  <= 1'b0;
            status_reg <= oldv_pkg::ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            op_reg     <= op_next;
            found_reg  <= found_next;
            status_reg <= status_next;
        end
    end

endmodule

// ----- sv/ordered_list_delete_by_value_unit.sv -----
// Ordered value list with append, delete-first-match and membership query.
//
// req (sink): opcode and signed value; an item is taken when valid and ready
// are both high. ready is high only while the controller is idle, so one
// item is worked on at a time.
// rsp (source): found, status and entry_count, one item per request item,
// in request order, held in an output register until taken.
//
// An unused opcode goes straight to the done state, and an append first
// checks for a full list. Delete and query walk the entry store one entry
// per cycle through its single registered read port. A delete stops the
// walk at the match and compacts the entries behind it, one per cycle.
// A new item is taken only after the controller has returned to idle.
//
// A new request is taken while a finished response still waits in the
// output register; that next item stalls only at its final step until the
// receiver takes the earlier response.
// Reset empties the list (count to zero) and drops any pending response;
// the store contents are not cleared, and entries past the count are
// never read.
module ordered_list_delete_by_value_unit (
    input  logic       clk,
    input  logic       rst_n,
    oldv_req_if.sink   req,
    oldv_rsp_if.source rsp
);

    oldv_pkg::cmd_t cmd;
    oldv_pkg::sts_t sts;

    // Sequence each item: decode, walk, compact, hand off the response
    oldv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .opcode   (req.opcode),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Hold entries, count, walk pointer and the response register
    oldv_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .value      (req.value),
        .out_valid  (rsp.valid),
        .out_ready  (rsp.ready),
        .out_found  (rsp.found),
        .out_status (rsp.status),
        .out_count  (rsp.entry_count)
    );

endmodule

// ----- sv/oldv_checker.sv -----
module oldv_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic                          found,
    input logic [oldv_pkg::STATUS_W-1:0] status,
    input logic [oldv_pkg::ECOUNT_W-1:0] entry_count
);

    // Stalled response holds its payload
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(found) && $stable(status)
            && $stable(entry_count))
        else $error("response changed while stalled");

    // Busy after taking an item
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken on back-to-back cycles");

    // A match never carries an error status
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> status == oldv_pkg::ST_OK)
        else $error("found set with non-ok status");

    // A dropped append means the list is full
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == oldv_pkg::ST_FULL
            |-> entry_count == oldv_pkg::ECOUNT_W'(oldv_pkg::CAPACITY))
        else $error("full status with list not full");

endmodule

bind ordered_list_delete_by_value_unit oldv_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (req.valid),
    .in_ready    (req.ready),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .found       (rsp.found),
    .status      (rsp.status),
    .entry_count (rsp.entry_count)
);
